FILE: rtl/core/lprd_pkg.sv
package lprd_pkg;

	localparam int PREFACE_LEN = 10;
	localparam int PRE_POS_W   = (PREFACE_LEN > 2) ? $clog2(PREFACE_LEN) : 1;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [15:0] MAX_LEN_RST = 16'hffff;
	localparam logic [15:0] VERSION_RST = 16'h0000;

	localparam logic [7:0] MAGIC [8] = '{8'h47, 8'h41, 8'h53, 8'h4f, 8'h4c, 8'h49, 8'h4e, 8'h45};

	typedef enum logic {
		REG_MAX_LEN = 1'b0,
		REG_VERSION = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_PREFACE = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		K_CONSUMED = 3'd0,
		K_PAYLOAD  = 3'd1,
		K_EMPTY    = 3'd2,
		K_ERROR    = 3'd3,
		K_FINISH   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		E_BAD_PREFACE   = 3'd0,
		E_OVERSIZED     = 3'd1,
		E_NOT_ACCEPTING = 3'd2,
		E_TRUNC_PREFACE = 3'd3,
		E_TRUNC_HEADER  = 3'd4,
		E_TRUNC_PAYLOAD = 3'd5
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
		logic [15:0] len;
		err_t        err;
		logic        stop;
	} item_t;

	function automatic logic [7:0] preface_expect(input logic [PRE_POS_W-1:0] pos,
		input logic [15:0] ver);
		logic [3:0] p4;
		p4 = 4'(pos);
		if (pos == PRE_POS_W'(PREFACE_LEN - 2))
			return ver[15:8];
		else if (pos == PRE_POS_W'(PREFACE_LEN - 1))
			return ver[7:0];
		else
			return MAGIC[p4[2:0]];
	endfunction

endpackage

FILE: rtl/core/length_prefixed_record_deframer.sv
// Length-prefixed record deframer.
// Input channel: one item per accepted push (push high, full low): a stream
// byte (req_type 0) or an end-of-stream request (req_type 1), with the
// downstream keep_going flag sampled when the byte closes a record.
// The stream opens with a fixed preface (magic bytes then a big-endian
// version), followed by records of a 2-byte big-endian length and payload.
// Result channel: exactly one result per item, oldest first, shown while
// empty is low and taken when pop is high. Payload bytes leave one per item.
// A result passes through the queue and then the output register before it
// is visible. Throughput: one item per cycle while full is low, set by the
// parser update in the front stage.
// A four-entry queue and the output register decouple the two sides; when
// the receiver stalls, results pile up and full rises once five are waiting.
// Reset clears the parser to the preface phase, empties the queue and sets
// the record length limit to 65535 and the expected version to 0. Write the
// registers only while the block is idle.
module length_prefixed_record_deframer import lprd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic        keep_going,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  out_kind,
	output logic [7:0]  payload_byte,
	output logic        record_last,
	output logic [15:0] record_length,
	output logic [2:0]  error_code,
	output logic        stopped
);

	item_t res;
	item_t head;
	logic  take;
	logic  q_pop;
	logic  q_empty;

	assign take = push && !full;

	lprd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.keep_going (keep_going),
		.res        (res)
	);

	lprd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_item (res),
		.pop       (q_pop),
		.head      (head),
		.full      (full),
		.empty     (q_empty)
	);

	lprd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (head),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.out_kind      (out_kind),
		.payload_byte  (payload_byte),
		.record_last   (record_last),
		.record_length (record_length),
		.error_code    (error_code),
		.stopped       (stopped)
	);

endmodule

FILE: rtl/core/lprd_front.sv
module lprd_front import lprd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        take,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic        keep_going,
	output item_t       res
);

	logic [15:0]          max_len_q;
	logic [15:0]          version_q;
	phase_t               phase_q, phase_d;
	logic [PRE_POS_W-1:0] pos_q, pos_d;
	logic                 half_q, half_d;
	logic [7:0]           len_hi_q, len_hi_d;
	logic [15:0]          left_q, left_d;
	logic [15:0]          rec_len_q, rec_len_d;
	logic                 failed_q, failed_d;
	logic                 finished_q, finished_d;

	logic [15:0] hdr_len;
	logic [15:0] left_dec;
	logic        pre_ok;

	assign hdr_len  = {len_hi_q, data_byte};
	assign left_dec = left_q - 16'd1;
	assign pre_ok   = (data_byte == preface_expect(pos_q, version_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			version_q <= VERSION_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_MAX_LEN: max_len_q <= cfg_wdata;
				REG_VERSION: version_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		half_d     = half_q;
		len_hi_d   = len_hi_q;
		left_d     = left_q;
		rec_len_d  = rec_len_q;
		failed_d   = failed_q;
		finished_d = finished_q;
		if (req_type) begin
			if (!failed_q && !finished_q) begin
				unique case (phase_q)
					PH_PREFACE, PH_PAYLOAD: failed_d = 1'b1;
					default: begin
						if (half_q)
							failed_d = 1'b1;
						else
							finished_d = 1'b1;
					end
				endcase
			end
		end else if (failed_q || finished_q) begin
			failed_d = 1'b1;
		end else begin
			unique case (phase_q)
				PH_PREFACE: begin
					if (!pre_ok) begin
						failed_d = 1'b1;
					end else if (pos_q == PRE_POS_W'(PREFACE_LEN - 1)) begin
						pos_d   = '0;
						phase_d = PH_HEADER;
					end else begin
						pos_d = pos_q + PRE_POS_W'(1);
					end
				end
				PH_PAYLOAD: begin
					left_d = left_dec;
					if (left_dec == 16'd0) begin
						phase_d = PH_HEADER;
						if (!keep_going)
							failed_d = 1'b1;
					end
				end
				default: begin
					if (!half_q) begin
						len_hi_d = data_byte;
						half_d   = 1'b1;
					end else begin
						half_d = 1'b0;
						if (hdr_len > max_len_q) begin
							failed_d = 1'b1;
						end else if (hdr_len == 16'd0) begin
							if (!keep_going)
								failed_d = 1'b1;
						end else begin
							rec_len_d = hdr_len;
							left_d    = hdr_len;
							phase_d   = PH_PAYLOAD;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		res      = '0;
		res.kind = K_CONSUMED;
		res.err  = E_BAD_PREFACE;
		res.data = data_byte;
		if (req_type) begin
			if (failed_q) begin
				res.kind = K_ERROR;
				res.err  = E_NOT_ACCEPTING;
			end else if (finished_q) begin
				res.kind = K_FINISH;
			end else begin
				unique case (phase_q)
					PH_PREFACE: begin
						res.kind = K_ERROR;
						res.err  = E_TRUNC_PREFACE;
					end
					PH_PAYLOAD: begin
						res.kind = K_ERROR;
						res.err  = E_TRUNC_PAYLOAD;
					end
					default: begin
						if (half_q) begin
							res.kind = K_ERROR;
							res.err  = E_TRUNC_HEADER;
						end else begin
							res.kind = K_FINISH;
						end
					end
				endcase
			end
		end else if (failed_q || finished_q) begin
			res.kind = K_ERROR;
			res.err  = E_NOT_ACCEPTING;
		end else begin
			unique case (phase_q)
				PH_PREFACE: begin
					if (!pre_ok) begin
						res.kind = K_ERROR;
						res.err  = E_BAD_PREFACE;
					end
				end
				PH_PAYLOAD: begin
					res.kind = K_PAYLOAD;
					res.len  = rec_len_q;
					res.last = (left_dec == 16'd0);
					res.stop = (left_dec == 16'd0) && !keep_going;
				end
				default: begin
					if (half_q) begin
						if (hdr_len > max_len_q) begin
							res.kind = K_ERROR;
							res.err  = E_OVERSIZED;
							res.len  = hdr_len;
						end else if (hdr_len == 16'd0) begin
							res.kind = K_EMPTY;
							res.stop = !keep_going;
						end else begin
							res.len = hdr_len;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PREFACE;
			pos_q      <= '0;
			half_q     <= 1'b0;
			len_hi_q   <= '0;
			left_q     <= '0;
			rec_len_q  <= '0;
			failed_q   <= 1'b0;
			finished_q <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			half_q     <= half_d;
			len_hi_q   <= len_hi_d;
			left_q     <= left_d;
			rec_len_q  <= rec_len_d;
			failed_q   <= failed_d;
			finished_q <= finished_d;
		end
	end

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q) else $error("failed flag cleared");
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != 16'd0) && (left_q <= rec_len_q))
		else $error("payload count out of range");
	a_preface_half: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER) |-> !half_q) else $error("header half outside header");

endmodule

FILE: rtl/core/lprd_queue.sv
module lprd_queue import lprd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	item_t              mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + Q_PTR_W'(1);
			if (pop)
				rd_q <= rd_q + Q_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + Q_CNT_W'(1)))
		else $error("queue count mismatch");

endmodule

FILE: rtl/core/lprd_back.sv
module lprd_back import lprd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  item_t       q_head,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  out_kind,
	output logic [7:0]  payload_byte,
	output logic        record_last,
	output logic [15:0] record_length,
	output logic [2:0]  error_code,
	output logic        stopped
);

	logic  valid_q;
	item_t item_q;
	item_t shaped;

	assign q_pop = !q_empty && (!valid_q || pop);
	assign empty = !valid_q;

	always_comb begin
		shaped = q_head;
		if (q_head.kind != K_PAYLOAD) begin
			shaped.data = '0;
			shaped.last = 1'b0;
		end
		if (q_head.kind != K_ERROR)
			shaped.err = E_BAD_PREFACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			item_q <= shaped;
	end

	assign out_kind      = item_q.kind;
	assign payload_byte  = item_q.data;
	assign record_last   = item_q.last;
	assign record_length = item_q.len;
	assign error_code    = item_q.err;
	assign stopped       = item_q.stop;

endmodule
